[hw/rtl/tmhs_pkg.sv]
// package for the timer min-heap scheduler
// types, codes and constants shared by controller, datapath and top level
`timescale 1ns / 1ps

package tmhs_pkg;

  localparam int unsigned DEFAULT_CAPACITY = 32;
  localparam int unsigned MAX_FIRINGS      = 32;
  localparam int unsigned FIRE_W           = $clog2(MAX_FIRINGS + 1);
  localparam int unsigned TIME_W           = 48;
  localparam int unsigned IVAL_W           = 24;
  localparam int unsigned TAG_W            = 32;

  typedef enum logic [1:0] {
    OP_TICK          = 2'd0,
    OP_ARM_PERIODIC  = 2'd1,
    OP_ARM_ONESHOT   = 2'd2,
    OP_CANCEL        = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    KIND_ARMED     = 3'd0,
    KIND_REJECTED  = 3'd1,
    KIND_CANCELLED = 3'd2,
    KIND_NOT_FOUND = 3'd3,
    KIND_FIRED     = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    S_IDLE, S_TICK, S_ARM, S_SCAN_RD, S_SCAN_CMP, S_REM_RD, S_REM_LD,
    S_DN_RD, S_DN_CMP, S_UP_RD, S_UP_CMP, S_DONE, S_CHK_RD, S_CHK, S_EMIT
  } state_e;

  typedef enum logic [1:0] {
    PH_ARM, PH_CANCEL, PH_FIRE_REM, PH_FIRE_INS
  } phase_e;

  typedef struct packed {
    logic [TIME_W-1:0] expiry;
    logic [IVAL_W-1:0] interval;
    logic [TAG_W-1:0]  tag;
    logic              oneshot;
  } entry_t;

  typedef struct packed {
    logic  latch_in;
    logic  tick;
    logic  load_new;
    logic  load_rearm;
    logic  rd_parent;
    logic  up_move;
    logic  wr_elem;
    logic  rd_kids;
    logic  dn_move;
    logic  rd_scan;
    logic  scan_next;
    logic  scan_hit;
    logic  rd_last;
    logic  rem_load;
    logic  rd_root;
    logic  fire_take;
    logic  emit_pend;
    logic  emit_res;
    logic  emit_last;
    kind_e res_kind;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic pos_zero;
    logic up_less;
    logic has_kid;
    logic dn_less;
    logic moved;
    logic scan_end;
    logic scan_match;
    logic rem_is_last;
    logic fire_due;
    logic fire_periodic;
    logic pend;
    logic out_free;
  } status_t;

endpackage

[hw/rtl/tmhs_ctrl.sv]
// controller state machine for the timer min-heap scheduler
// sequences scan, removal, sift and firing steps; uses tmhs_pkg
`timescale 1ns / 1ps

module tmhs_ctrl import tmhs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  logic [1:0] operation_i,
  input  status_t st_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  kind_e  kind_q, kind_d;
  op_e    op_in;

  assign op_in = op_e'(operation_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_ARM;
      kind_q  <= KIND_ARMED;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      kind_q  <= kind_d;
    end
  end

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    kind_d  = kind_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (op_in)
            OP_TICK:                          state_d = S_TICK;
            OP_ARM_PERIODIC, OP_ARM_ONESHOT:  state_d = S_ARM;
            OP_CANCEL:                        state_d = S_SCAN_RD;
            default:                          state_d = S_IDLE;
          endcase
        end
      end
      S_TICK:   state_d = S_CHK_RD;
      S_ARM: begin
        if (st_i.full) begin
          kind_d  = KIND_REJECTED;
          state_d = S_EMIT;
        end else begin
          phase_d = PH_ARM;
          state_d = S_UP_RD;
        end
      end
      S_SCAN_RD: begin
        if (st_i.scan_end) begin
          kind_d  = KIND_NOT_FOUND;
          state_d = S_EMIT;
        end else begin
          state_d = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (st_i.scan_match) begin
          phase_d = PH_CANCEL;
          state_d = S_REM_RD;
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      S_REM_RD: state_d = S_REM_LD;
      S_REM_LD: state_d = st_i.rem_is_last ? S_DONE : S_DN_RD;
      S_DN_RD: begin
        if (!st_i.has_kid) state_d = st_i.moved ? S_DONE : S_UP_RD;
        else               state_d = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (st_i.dn_less) state_d = S_DN_RD;
        else              state_d = st_i.moved ? S_DONE : S_UP_RD;
      end
      S_UP_RD:  state_d = st_i.pos_zero ? S_DONE : S_UP_CMP;
      S_UP_CMP: state_d = st_i.up_less ? S_UP_RD : S_DONE;
      S_DONE: begin
        unique case (phase_q)
          PH_ARM: begin
            kind_d  = KIND_ARMED;
            state_d = S_EMIT;
          end
          PH_CANCEL: begin
            kind_d  = KIND_CANCELLED;
            state_d = S_EMIT;
          end
          PH_FIRE_REM: begin
            if (st_i.fire_periodic) begin
              phase_d = PH_FIRE_INS;
              state_d = S_UP_RD;
            end else begin
              state_d = S_CHK_RD;
            end
          end
          PH_FIRE_INS: state_d = S_CHK_RD;
          default:     state_d = S_CHK_RD;
        endcase
      end
      S_CHK_RD: state_d = S_CHK;
      S_CHK: begin
        if (!st_i.pend || st_i.out_free) begin
          if (st_i.fire_due) begin
            phase_d = PH_FIRE_REM;
            state_d = S_REM_RD;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_EMIT:   if (st_i.out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.res_kind = kind_q;
    in_ready_o     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.latch_in = in_valid_i;
      end
      S_TICK:     cmd_o.tick = 1'b1;
      S_ARM:      cmd_o.load_new = !st_i.full;
      S_SCAN_RD:  cmd_o.rd_scan = !st_i.scan_end;
      S_SCAN_CMP: begin
        cmd_o.scan_hit  = st_i.scan_match;
        cmd_o.scan_next = !st_i.scan_match;
      end
      S_REM_RD:   cmd_o.rd_last = 1'b1;
      S_REM_LD:   cmd_o.rem_load = 1'b1;
      S_DN_RD: begin
        cmd_o.rd_kids = st_i.has_kid;
        cmd_o.wr_elem = !st_i.has_kid && st_i.moved;
      end
      S_DN_CMP: begin
        cmd_o.dn_move = st_i.dn_less;
        cmd_o.wr_elem = !st_i.dn_less && st_i.moved;
      end
      S_UP_RD: begin
        cmd_o.rd_parent = !st_i.pos_zero;
        cmd_o.wr_elem   = st_i.pos_zero;
      end
      S_UP_CMP: begin
        cmd_o.up_move = st_i.up_less;
        cmd_o.wr_elem = !st_i.up_less;
      end
      S_DONE:     cmd_o.load_rearm = (phase_q == PH_FIRE_REM) && st_i.fire_periodic;
      S_CHK_RD:   cmd_o.rd_root = 1'b1;
      S_CHK: begin
        if (!st_i.pend || st_i.out_free) begin
          cmd_o.emit_pend = st_i.pend;
          cmd_o.emit_last = !st_i.fire_due;
          cmd_o.fire_take = st_i.fire_due;
        end
      end
      S_EMIT:     cmd_o.emit_res = st_i.out_free;
      default:    cmd_o = '0;
    endcase
  end

endmodule

[hw/rtl/tmhs_datapath.sv]
// datapath for the timer min-heap scheduler: heap memory, time counter,
// sift registers and result register; uses tmhs_pkg
`timescale 1ns / 1ps

module tmhs_datapath import tmhs_pkg::*; #(
  parameter int unsigned TIMER_CAPACITY = DEFAULT_CAPACITY
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output status_t           st_o,
  input  logic [1:0]        operation_i,
  input  logic [IVAL_W-1:0] interval_ms_i,
  input  logic [TAG_W-1:0]  tag_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        result_kind_o,
  output logic [TAG_W-1:0]  tag_out_o,
  output logic [TIME_W-1:0] fire_time_ms_o,
  output logic              last_o
);

  localparam int unsigned IDX_W = (TIMER_CAPACITY > 1) ? $clog2(TIMER_CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(TIMER_CAPACITY + 1);
  localparam int unsigned KID_W = IDX_W + 2;

  entry_t heap_mem_q [TIMER_CAPACITY];
  entry_t rd_a_q, rd_b_q, elem_q, elem_d, fire_q, pick, wr_data;
  logic [IDX_W-1:0]  pos_q, pos_d, parent, rd_a_addr, wr_addr, pick_idx;
  logic [CNT_W-1:0]  count_q, count_d, scan_q, scan_d, count_m1;
  logic [TIME_W-1:0] now_q, now_d;
  logic [IVAL_W-1:0] ival_q, ival_fix, rearm_fix;
  logic [TAG_W-1:0]  tag_q;
  logic              oneshot_q, moved_q, moved_d, pend_q, pend_d;
  logic [FIRE_W-1:0] fires_q, fires_d;
  logic [KID_W-1:0]  lc, rc, count_k;
  logic              rc_ok, pick_right, rd_a_en, we, out_free, out_load;
  logic              out_valid_q, last_q;
  kind_e             kind_q;
  logic [TAG_W-1:0]  otag_q;
  logic [TIME_W-1:0] otime_q;

  assign count_m1  = count_q - 1'b1;
  assign parent    = (pos_q - 1'b1) >> 1;
  assign lc        = {1'b0, pos_q, 1'b1};
  assign rc        = {1'b0, pos_q, 1'b0} + KID_W'(2);
  assign count_k   = KID_W'(count_q);
  assign rc_ok     = rc < count_k;
  assign pick_right = rc_ok && !(rd_a_q.expiry < rd_b_q.expiry);
  assign pick      = pick_right ? rd_b_q : rd_a_q;
  assign pick_idx  = pick_right ? rc[IDX_W-1:0] : lc[IDX_W-1:0];
  assign ival_fix  = (ival_q == '0) ? IVAL_W'(1) : ival_q;
  assign rearm_fix = (fire_q.interval == '0) ? IVAL_W'(1) : fire_q.interval;
  assign out_free  = !out_valid_q || out_ready_i;
  assign out_load  = cmd_i.emit_pend || cmd_i.emit_res;

  always_comb begin
    rd_a_en   = 1'b1;
    rd_a_addr = '0;
    if (cmd_i.rd_parent)    rd_a_addr = parent;
    else if (cmd_i.rd_kids) rd_a_addr = lc[IDX_W-1:0];
    else if (cmd_i.rd_scan) rd_a_addr = scan_q[IDX_W-1:0];
    else if (cmd_i.rd_last) rd_a_addr = count_m1[IDX_W-1:0];
    else if (cmd_i.rd_root) rd_a_addr = '0;
    else                    rd_a_en   = 1'b0;
  end

  always_comb begin
    we      = cmd_i.up_move || cmd_i.wr_elem || cmd_i.dn_move;
    wr_addr = pos_q;
    if (cmd_i.up_move)      wr_data = rd_a_q;
    else if (cmd_i.dn_move) wr_data = pick;
    else                    wr_data = elem_q;
  end

  always_ff @(posedge clk_i) begin
    if (we) heap_mem_q[wr_addr] <= wr_data;
    if (rd_a_en) rd_a_q <= heap_mem_q[rd_a_addr];
    if (cmd_i.rd_kids) rd_b_q <= heap_mem_q[rc[IDX_W-1:0]];
  end

  always_comb begin
    elem_d  = elem_q;
    pos_d   = pos_q;
    count_d = count_q;
    scan_d  = scan_q;
    now_d   = now_q;
    moved_d = moved_q;
    pend_d  = pend_q;
    fires_d = fires_q;
    if (cmd_i.latch_in) scan_d = '0;
    if (cmd_i.tick) begin
      now_d   = now_q + 1'b1;
      fires_d = '0;
      pend_d  = 1'b0;
    end
    if (cmd_i.load_new) begin
      elem_d.expiry   = now_q + TIME_W'(ival_fix);
      elem_d.interval = ival_fix;
      elem_d.tag      = tag_q;
      elem_d.oneshot  = oneshot_q;
      pos_d   = count_q[IDX_W-1:0];
      count_d = count_q + 1'b1;
    end
    if (cmd_i.load_rearm) begin
      elem_d.expiry   = now_q + TIME_W'(rearm_fix);
      elem_d.interval = rearm_fix;
      elem_d.tag      = fire_q.tag;
      elem_d.oneshot  = 1'b0;
      pos_d   = count_q[IDX_W-1:0];
      count_d = count_q + 1'b1;
    end
    if (cmd_i.up_move) pos_d = parent;
    if (cmd_i.dn_move) begin
      pos_d   = pick_idx;
      moved_d = 1'b1;
    end
    if (cmd_i.scan_next) scan_d = scan_q + 1'b1;
    if (cmd_i.scan_hit)  pos_d  = scan_q[IDX_W-1:0];
    if (cmd_i.rem_load) begin
      elem_d  = rd_a_q;
      count_d = count_m1;
      moved_d = 1'b0;
    end
    if (cmd_i.fire_take) begin
      pend_d  = 1'b1;
      fires_d = fires_q + 1'b1;
      pos_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      now_q       <= '0;
      pend_q      <= 1'b0;
      fires_q     <= '0;
      moved_q     <= 1'b0;
      scan_q      <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      now_q   <= now_d;
      pend_q  <= pend_d;
      fires_q <= fires_d;
      moved_q <= moved_d;
      scan_q  <= scan_d;
      pos_q   <= pos_d;
      if (out_load)         out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    elem_q <= elem_d;
    if (cmd_i.latch_in) begin
      ival_q    <= interval_ms_i;
      tag_q     <= tag_i;
      oneshot_q <= (op_e'(operation_i) == OP_ARM_ONESHOT);
    end
    if (cmd_i.fire_take) fire_q <= rd_a_q;
    if (cmd_i.emit_pend) begin
      kind_q  <= KIND_FIRED;
      otag_q  <= fire_q.tag;
      otime_q <= now_q;
      last_q  <= cmd_i.emit_last;
    end else if (cmd_i.emit_res) begin
      kind_q  <= cmd_i.res_kind;
      otag_q  <= tag_q;
      otime_q <= now_q;
      last_q  <= 1'b1;
    end
  end

  assign st_o.full          = (count_q == CNT_W'(TIMER_CAPACITY));
  assign st_o.pos_zero      = (pos_q == '0);
  assign st_o.up_less       = elem_q.expiry < rd_a_q.expiry;
  assign st_o.has_kid       = lc < count_k;
  assign st_o.dn_less       = pick.expiry < elem_q.expiry;
  assign st_o.moved         = moved_q;
  assign st_o.scan_end      = (scan_q == count_q);
  assign st_o.scan_match    = (rd_a_q.tag == tag_q);
  assign st_o.rem_is_last   = (CNT_W'(pos_q) == count_m1);
  assign st_o.fire_due      = (count_q != '0) && (fires_q < FIRE_W'(MAX_FIRINGS))
                              && (rd_a_q.expiry <= now_q);
  assign st_o.fire_periodic = !fire_q.oneshot;
  assign st_o.pend          = pend_q;
  assign st_o.out_free      = out_free;

  assign out_valid_o    = out_valid_q;
  assign result_kind_o  = kind_q;
  assign tag_out_o      = otag_q;
  assign fire_time_ms_o = otime_q;
  assign last_o         = last_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TIMER_CAPACITY)) else $error("heap count overflow");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free) else $error("result beat overwritten");
  a_fire_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fires_q <= FIRE_W'(MAX_FIRINGS)) else $error("too many firings");
  a_single_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd_i.up_move, cmd_i.wr_elem, cmd_i.dn_move}) <= 1)
    else $error("two heap writes in one cycle");
`endif

endmodule

[hw/rtl/timer_min_heap_scheduler_core.sv]
// Timer queue kept as a binary min-heap by expiry time, 48-bit ms counter.
//
// Input channel (in_valid_i/in_ready_o): one beat is one item, operation_i
// selects tick, arm periodic, arm one-shot or cancel by tag. in_ready_o is
// high only while the controller is idle; items are worked one at a time.
// Output channel (out_valid_o/out_ready_i): one beat per result, last_o
// marks the final result of an item. Arm and cancel give one result, a tick
// gives one result per fired timer (up to 32) or none.
// Steps per item: arm loads the entry and sifts it up level by level;
// cancel scans the entries one by one, then removes the match; tick
// checks the root, then per firing removes it with a sift-down and, for
// a periodic timer, re-inserts it with a sift-up for the re-arm.
// Each heap step is a registered memory read followed by one compare.
// Reset clears the count and time counter; heap contents need no clearing.
// A stalled receiver holds the result register; the controller waits before
// loading the next result, so no beat is lost. Depends on tmhs_pkg.
`timescale 1ns / 1ps

module timer_min_heap_scheduler_core import tmhs_pkg::*; #(
  parameter int unsigned TIMER_CAPACITY = DEFAULT_CAPACITY
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        operation_i,
  input  logic [IVAL_W-1:0] interval_ms_i,
  input  logic [TAG_W-1:0]  tag_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        result_kind_o,
  output logic [TAG_W-1:0]  tag_out_o,
  output logic [TIME_W-1:0] fire_time_ms_o,
  output logic              last_o
);

  cmd_t    cmd;
  status_t st;

  tmhs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  tmhs_datapath #(
    .TIMER_CAPACITY (TIMER_CAPACITY)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .st_o           (st),
    .operation_i    (operation_i),
    .interval_ms_i  (interval_ms_i),
    .tag_i          (tag_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_kind_o  (result_kind_o),
    .tag_out_o      (tag_out_o),
    .fire_time_ms_o (fire_time_ms_o),
    .last_o         (last_o)
  );

endmodule

[dv/tb_timer_min_heap_scheduler_core.sv]
// testbench for timer_min_heap_scheduler_core: directed and random items
// checked against a min-heap timer queue predictor kept in a scoreboard class
// depends on tmhs_pkg and the core rtl
`timescale 1ns / 1ps

module tb_timer_min_heap_scheduler_core;
  import tmhs_pkg::*;

  localparam int unsigned CAP = 32;
  localparam int unsigned STALL_LIMIT = 5000;

  typedef struct packed {
    logic [2:0]        kind;
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] stamp;
    logic              last;
  } timer_result_t;

  class timer_queue_sb;
    logic [TIME_W-1:0] expiry[CAP];
    logic [IVAL_W-1:0] period[CAP];
    logic [TAG_W-1:0]  tags[CAP];
    bit                oneshot[CAP];
    int unsigned       count;
    logic [TIME_W-1:0] now;
    timer_result_t     expected_q[$];
    int                errors;

    function new();
      count = 0;
      now = '0;
      errors = 0;
    endfunction

    function void swap(int unsigned a, int unsigned b);
      logic [TIME_W-1:0] e;
      logic [IVAL_W-1:0] p;
      logic [TAG_W-1:0] t;
      bit o;
      e = expiry[a]; p = period[a]; t = tags[a]; o = oneshot[a];
      expiry[a] = expiry[b]; period[a] = period[b]; tags[a] = tags[b];
      oneshot[a] = oneshot[b];
      expiry[b] = e; period[b] = p; tags[b] = t; oneshot[b] = o;
    endfunction

    function void sift_up(int unsigned pos);
      int unsigned up;
      while (pos > 0) begin
        up = (pos + 1) / 2 - 1;
        if (expiry[pos] < expiry[up]) begin
          swap(pos, up);
          pos = up;
        end else begin
          break;
        end
      end
    endfunction

    function void sift_down(int unsigned pos);
      int unsigned lc, rc, pick;
      while (pos < count) begin
        lc = 2 * pos + 1;
        rc = 2 * pos + 2;
        if (rc < count) pick = (expiry[lc] < expiry[rc]) ? lc : rc;
        else if (lc < count) pick = lc;
        else break;
        if (expiry[pick] < expiry[pos]) begin
          swap(pick, pos);
          pos = pick;
        end else begin
          break;
        end
      end
    endfunction

    function void remove_at(int unsigned pos);
      int unsigned lastpos;
      lastpos = count - 1;
      if (pos != lastpos) begin
        expiry[pos] = expiry[lastpos]; period[pos] = period[lastpos];
        tags[pos] = tags[lastpos]; oneshot[pos] = oneshot[lastpos];
      end
      count--;
      if (pos < count) begin
        sift_down(pos);
        sift_up(pos);
      end
    endfunction

    function void insert(logic [IVAL_W-1:0] ivl, logic [TAG_W-1:0] tag, bit os);
      if (ivl == 0) ivl = 1;
      expiry[count] = now + TIME_W'(ivl);
      period[count] = ivl;
      tags[count] = tag;
      oneshot[count] = os;
      count++;
      sift_up(count - 1);
    endfunction

    function void push(kind_e kind, logic [TAG_W-1:0] tag);
      timer_result_t r;
      r.kind = kind;
      r.tag = tag;
      r.stamp = now;
      r.last = 1'b0;
      expected_q.push_back(r);
    endfunction

    function void note_item(op_e op, logic [IVAL_W-1:0] ivl, logic [TAG_W-1:0] tag);
      int n;
      bit found;
      logic [TAG_W-1:0] ftag;
      logic [IVAL_W-1:0] fper;
      bit fos;
      n = 0;
      found = 0;
      if (op == OP_ARM_PERIODIC || op == OP_ARM_ONESHOT) begin
        if (count >= CAP) begin
          push(KIND_REJECTED, tag);
        end else begin
          insert(ivl, tag, op == OP_ARM_ONESHOT);
          push(KIND_ARMED, tag);
        end
        n = 1;
      end else if (op == OP_CANCEL) begin
        for (int unsigned i = 0; i < count; i++) begin
          if (tags[i] == tag) begin
            remove_at(i);
            found = 1;
            break;
          end
        end
        if (found) push(KIND_CANCELLED, tag);
        else push(KIND_NOT_FOUND, tag);
        n = 1;
      end else begin
        now = now + 1;
        while (n < MAX_FIRINGS && count > 0 && expiry[0] <= now) begin
          ftag = tags[0];
          fper = period[0];
          fos = oneshot[0];
          push(KIND_FIRED, ftag);
          n++;
          remove_at(0);
          if (!fos) insert(fper, ftag, 0);
        end
      end
      if (n > 0) expected_q[expected_q.size() - 1].last = 1'b1;
    endfunction

    function void check(logic [2:0] kind, logic [TAG_W-1:0] tag,
                        logic [TIME_W-1:0] stamp, logic last);
      timer_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result kind %0d tag %h time %0d last %0b",
                 $time, kind, tag, stamp, last);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (kind !== e.kind) begin
        $display("%0t: result_kind expected %0d actual %0d", $time, e.kind, kind);
        errors++;
      end
      if (tag !== e.tag) begin
        $display("%0t: tag_out expected %h actual %h", $time, e.tag, tag);
        errors++;
      end
      if (stamp !== e.stamp) begin
        $display("%0t: fire_time_ms expected %0d actual %0d", $time, e.stamp, stamp);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: last expected %0b actual %0b", $time, e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [1:0]        operation_i = '0;
  logic [IVAL_W-1:0] interval_ms_i = '0;
  logic [TAG_W-1:0]  tag_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [2:0]        result_kind_o;
  logic [TAG_W-1:0]  tag_out_o;
  logic [TIME_W-1:0] fire_time_ms_o;
  logic              last_o;

  timer_queue_sb sb = new();
  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned quiet_cycles = 0;

  timer_min_heap_scheduler_core dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .operation_i, .interval_ms_i,
    .tag_i, .out_valid_o, .out_ready_i, .result_kind_o, .tag_out_o,
    .fire_time_ms_o, .last_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check(result_kind_o, tag_out_o, fire_time_ms_o, last_o);
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_item(op_e op, logic [IVAL_W-1:0] ivl, logic [TAG_W-1:0] tag);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    interval_ms_i <= ivl;
    tag_i <= tag;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(op, ivl, tag);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  task automatic send_random();
    int unsigned r;
    logic [IVAL_W-1:0] ivl;
    logic [TAG_W-1:0] tag;
    op_e op;
    r = $urandom_range(99);
    if (r < 40) op = OP_TICK;
    else if (r < 58) op = OP_ARM_PERIODIC;
    else if (r < 76) op = OP_ARM_ONESHOT;
    else op = OP_CANCEL;
    r = $urandom_range(99);
    if (r < 70) ivl = IVAL_W'($urandom_range(6));
    else if (r < 90) ivl = IVAL_W'($urandom_range(40, 1));
    else ivl = IVAL_W'($urandom);
    tag = ($urandom_range(99) < 85) ? $urandom_range(15) : $urandom;
    send_item(op, ivl, tag);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: extremes, zero interval, equal expiry, miss and hit cancel
    send_item(OP_TICK, '0, '0);
    send_item(OP_CANCEL, '0, 32'hffff_ffff);
    send_item(OP_ARM_PERIODIC, '0, '0);
    send_item(OP_ARM_ONESHOT, 24'hff_ffff, 32'hffff_ffff);
    send_item(OP_ARM_ONESHOT, 24'd2, 32'h5555_5555);
    send_item(OP_ARM_ONESHOT, 24'd2, 32'haaaa_aaaa);
    send_item(OP_ARM_PERIODIC, 24'd2, 32'h1234_5678);
    send_item(OP_TICK, '0, '0);
    send_item(OP_TICK, '0, '0);
    send_item(OP_CANCEL, '0, 32'hffff_ffff);
    send_item(OP_CANCEL, '0, 32'h1234_5678);
    send_item(OP_CANCEL, '0, '0);
    send_item(OP_TICK, '0, '0);
    drain();

    // fill to capacity, one rejected arm, then a tick firing every entry
    for (int i = 0; i < CAP; i++)
      send_item((i % 2) ? OP_ARM_ONESHOT : OP_ARM_PERIODIC, 24'd1, 32'(i));
    send_item(OP_ARM_PERIODIC, 24'd1, 32'hdead_beef);
    drain();
    send_item(OP_TICK, '0, '0);
    send_item(OP_TICK, '0, '0);
    for (int i = 0; i < CAP; i += 2) send_item(OP_CANCEL, '0, 32'(i));
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0; snk_stall_pct = 0; end
        1: begin src_idle_pct = 61; snk_stall_pct = 0; end
        2: begin src_idle_pct = 0; snk_stall_pct = 61; end
        default: begin src_idle_pct = 31; snk_stall_pct = 31; end
      endcase
      for (int i = 0; i < 60; i++) send_random();
      drain();
    end
    src_idle_pct = 0;
    snk_stall_pct = 0;
    for (int i = 0; i < 30; i++) send_random();
    drain();

    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/tmhs_pkg.sv
hw/rtl/tmhs_ctrl.sv
hw/rtl/tmhs_datapath.sv
hw/rtl/timer_min_heap_scheduler_core.sv
dv/tb_timer_min_heap_scheduler_core.sv
